@@ rtl/mcips_pkg.sv @@
// package: widths, microcode word layout and the control program of the smoother bank
`timescale 1ns / 1ps
package mcips_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_W     = 4;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int VAL_W      = 32;
  localparam int COEF_W     = 18;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = COEF_W + VAL_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam int RND_W      = ACC_W - FRAC_W;
  localparam int CFG_IDX_W  = 2;
  localparam int PC_W       = 3;

  localparam logic signed [COEF_W-1:0] COEF_FB1_RST     = '0;
  localparam logic signed [COEF_W-1:0] COEF_FB2_RST     = '0;
  localparam logic signed [COEF_W-1:0] COEF_IN_NOW_RST  = COEF_W'(65536);
  localparam logic signed [COEF_W-1:0] COEF_IN_PREV_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FB1, REG_FB2, REG_IN_NOW, REG_IN_PREV
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MUL_FB1, MUL_FB2, MUL_IN_NOW, MUL_IN_PREV
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD, ACC_LOAD, ACC_ADD
  } acc_op_t;

  // conditional jump: take target when the condition holds, else fall through
  typedef enum logic [1:0] {
    JMP_NEXT, JMP_NO_INPUT, JMP_NOT_STEP, JMP_OUT_HOLD
  } jump_t;

  localparam logic [PC_W-1:0] PC_IDLE   = PC_W'(0);
  localparam logic [PC_W-1:0] PC_FINISH = PC_W'(7);

  typedef struct packed {
    logic            ready;
    mul_sel_t        mul_sel;
    acc_op_t         acc_op;
    logic            round;
    logic            finish;
    jump_t           jump;
    logic [PC_W-1:0] target;
  } uword_t;

  typedef struct packed {
    logic in_valid;
    logic step_ok;
    logic out_hold;
  } seq_stat_t;

  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{ready: 1'b0, mul_sel: MUL_FB1, acc_op: ACC_HOLD, round: 1'b0,
          finish: 1'b0, jump: JMP_NEXT, target: PC_IDLE};
    case (pc)
      3'd0: begin
        w.ready  = 1'b1;
        w.jump   = JMP_NO_INPUT;
        w.target = PC_IDLE;
      end
      3'd1: begin
        // start items and bad slots skip the arithmetic
        w.mul_sel = MUL_FB1;
        w.jump    = JMP_NOT_STEP;
        w.target  = PC_FINISH;
      end
      3'd2: begin
        w.mul_sel = MUL_FB2;
        w.acc_op  = ACC_LOAD;
      end
      3'd3: begin
        w.mul_sel = MUL_IN_NOW;
        w.acc_op  = ACC_ADD;
      end
      3'd4: begin
        w.mul_sel = MUL_IN_PREV;
        w.acc_op  = ACC_ADD;
      end
      3'd5: begin
        w.acc_op = ACC_ADD;
      end
      3'd6: begin
        w.round = 1'b1;
      end
      3'd7: begin
        // wait here while the output register is still occupied
        w.finish = 1'b1;
        w.jump   = JMP_OUT_HOLD;
        w.target = PC_FINISH;
      end
      default: begin
        w.jump   = JMP_NEXT;
      end
    endcase
    return w;
  endfunction

endpackage

@@ rtl/mcips_seq.sv @@
// microcode sequencer: step counter, control rom lookup and conditional jumps
`timescale 1ns / 1ps
module mcips_seq
  import mcips_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  seq_stat_t stat,
  output uword_t    uw
);

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign uw = ucode_rom(pc_r);

  always_comb begin
    case (uw.jump)
      JMP_NO_INPUT: take = !stat.in_valid;
      JMP_NOT_STEP: take = !stat.step_ok;
      JMP_OUT_HOLD: take = stat.out_hold;
      default:      take = 1'b0;
    endcase
    pc_nxt = take ? uw.target : pc_r + PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_IDLE;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

@@ rtl/mcips_dp.sv @@
// datapath: coefficients, per-slot history, shared multiplier, accumulator, output register
`timescale 1ns / 1ps
module mcips_dp
  import mcips_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  uword_t                uw,
  output seq_stat_t             stat,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [COEF_W-1:0]     cfg_wdata,
  input  logic                  in_valid,
  input  logic                  in_op,
  input  logic [SLOT_W-1:0]     in_slot,
  input  logic [VAL_W-1:0]      in_start_value,
  input  logic [VAL_W-1:0]      in_target_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [VAL_W-1:0]      out_smoothed,
  output logic                  out_bad_slot
);

  logic signed [COEF_W-1:0] fb1_r, fb2_r, in_now_c_r, in_prev_c_r;

  logic [VAL_W-1:0]      y1_r [SLOT_COUNT];
  logic [VAL_W-1:0]      y2_r [SLOT_COUNT];
  logic [VAL_W-1:0]      x1_r [SLOT_COUNT];
  logic [VAL_W-1:0]      x0_r [SLOT_COUNT];
  logic [SLOT_COUNT-1:0] hist_vld_r;

  logic                  op_r;
  logic                  bad_r;
  logic [SLOT_W-1:0]     slot_r;
  logic [VAL_W-1:0]      start_r;
  logic [VAL_W-1:0]      target_r;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;
  logic [VAL_W-1:0]         res_r;

  logic                  out_valid_r;
  logic [VAL_W-1:0]      out_smoothed_r;
  logic                  out_bad_slot_r;

  logic [SLOT_IDX_W-1:0]    idx;
  logic [VAL_W-1:0]         y1, y2, x1, x0;
  logic signed [COEF_W-1:0] coef_sel;
  logic signed [VAL_W-1:0]  val_sel;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  prod_ext;
  logic signed [ACC_W-1:0]  biased;
  logic [RND_W-1:0]         rnd;
  logic [VAL_W-1:0]         sat;
  logic                     in_xfer;
  logic                     in_bad;
  logic                     out_hold;
  logic                     commit;
  logic                     step_ok;

  assign in_xfer  = in_valid && uw.ready;
  assign in_bad   = {1'b0, in_slot} >= (SLOT_W + 1)'(SLOT_COUNT);
  assign out_hold = out_valid_r && out_stall;
  assign commit   = uw.finish && !out_hold;
  assign step_ok  = op_r && !bad_r;

  assign stat = '{in_valid: in_valid, step_ok: step_ok, out_hold: out_hold};

  assign idx = slot_r[SLOT_IDX_W-1:0];
  // slots never written since reset read as zero
  assign y1  = hist_vld_r[idx] ? y1_r[idx] : '0;
  assign y2  = hist_vld_r[idx] ? y2_r[idx] : '0;
  assign x1  = hist_vld_r[idx] ? x1_r[idx] : '0;
  assign x0  = hist_vld_r[idx] ? x0_r[idx] : '0;

  always_comb begin
    case (uw.mul_sel)
      MUL_FB1: begin
        coef_sel = fb1_r;
        val_sel  = $signed(y1);
      end
      MUL_FB2: begin
        coef_sel = fb2_r;
        val_sel  = $signed(y2);
      end
      MUL_IN_NOW: begin
        coef_sel = in_now_c_r;
        val_sel  = $signed(x0);
      end
      MUL_IN_PREV: begin
        coef_sel = in_prev_c_r;
        val_sel  = $signed(x1);
      end
      default: begin
        coef_sel = fb1_r;
        val_sel  = $signed(y1);
      end
    endcase
  end

  assign prod     = coef_sel * val_sel;
  assign prod_ext = {{(ACC_W - PROD_W){prod_r[PROD_W-1]}}, prod_r};

  // round half up to q16.16, then clamp to the 32-bit range
  assign biased = acc_r + ACC_W'(1 << (FRAC_W - 1));
  assign rnd    = biased[ACC_W-1:FRAC_W];

  always_comb begin
    if (rnd[RND_W-1:VAL_W-1] == '0 || rnd[RND_W-1:VAL_W-1] == '1) begin
      sat = rnd[VAL_W-1:0];
    end else if (rnd[RND_W-1]) begin
      sat = {1'b1, {(VAL_W - 1){1'b0}}};
    end else begin
      sat = {1'b0, {(VAL_W - 1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fb1_r       <= COEF_FB1_RST;
      fb2_r       <= COEF_FB2_RST;
      in_now_c_r  <= COEF_IN_NOW_RST;
      in_prev_c_r <= COEF_IN_PREV_RST;
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_index))
        REG_FB1:     fb1_r       <= $signed(cfg_wdata);
        REG_FB2:     fb2_r       <= $signed(cfg_wdata);
        REG_IN_NOW:  in_now_c_r  <= $signed(cfg_wdata);
        REG_IN_PREV: in_prev_c_r <= $signed(cfg_wdata);
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_r     <= in_op;
      bad_r    <= in_bad;
      slot_r   <= in_slot;
      start_r  <= in_start_value;
      target_r <= in_target_value;
    end
    prod_r <= prod;
    case (uw.acc_op)
      ACC_LOAD: acc_r <= prod_ext;
      ACC_ADD:  acc_r <= acc_r + prod_ext;
      default:  acc_r <= acc_r;
    endcase
    if (uw.round) begin
      res_r <= sat;
    end
    if (commit && !bad_r) begin
      if (op_r) begin
        x1_r[idx] <= x0;
        y2_r[idx] <= y1;
        y1_r[idx] <= res_r;
        x0_r[idx] <= x0;
      end else begin
        x1_r[idx] <= start_r;
        y2_r[idx] <= start_r;
        y1_r[idx] <= start_r;
        x0_r[idx] <= target_r;
      end
    end
    if (commit) begin
      out_smoothed_r <= step_ok ? res_r : '0;
      out_bad_slot_r <= bad_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (commit && !bad_r) begin
        hist_vld_r[idx] <= 1'b1;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid    = out_valid_r;
  assign out_smoothed = out_smoothed_r;
  assign out_bad_slot = out_bad_slot_r;

endmodule

@@ rtl/multi_channel_iir_param_smoother_top.sv @@
// second-order smoother bank: a step item sums its four products, rounds, then registers the result
// at the finish step; start items and bad slots skip to it; one item is in work at a time,
// so the next transfer waits for the finish step, which holds while the output register stalls
// the four products share one 18x32 multiplier, one product per cycle, then round and clamp
// a new item is taken while the previous result still waits in the output register
// synchronous active-low reset: coefficients to defaults, all slot histories read as zero
`timescale 1ns / 1ps
module multi_channel_iir_param_smoother_top
  import mcips_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [COEF_W-1:0]    cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [SLOT_W-1:0]    in_slot,
  input  logic [VAL_W-1:0]     in_start_value,
  input  logic [VAL_W-1:0]     in_target_value,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [VAL_W-1:0]     out_smoothed,
  output logic                 out_bad_slot
);

  uword_t    uw;
  seq_stat_t stat;

  assign in_stall = !uw.ready;

  mcips_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .uw    (uw)
  );

  mcips_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .uw              (uw),
    .stat            (stat),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_op           (in_op),
    .in_slot         (in_slot),
    .in_start_value  (in_start_value),
    .in_target_value (in_target_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_smoothed    (out_smoothed),
    .out_bad_slot    (out_bad_slot)
  );

endmodule
